/* sv/bde_pkg.sv */
// Shared codes, constants and calendar helpers for the button date editor.
package bde_pkg;

	localparam int YEAR_W = 14;

	// Operation codes
	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_UP     = 3'd1;
	localparam logic [2:0] OP_DOWN   = 3'd2;
	localparam logic [2:0] OP_SELECT = 3'd3;
	localparam logic [2:0] OP_BACK   = 3'd4;

	// Event result codes
	localparam logic [1:0] RES_IGNORED   = 2'd0;
	localparam logic [1:0] RES_UPDATED   = 2'd1;
	localparam logic [1:0] RES_COMMITTED = 2'd2;
	localparam logic [1:0] RES_CANCELLED = 2'd3;

	// Focus codes
	localparam logic [1:0] SEL_MONTH = 2'd0;
	localparam logic [1:0] SEL_DAY   = 2'd1;
	localparam logic [1:0] SEL_YEAR  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_YR_LO = 2'd0;
	localparam logic [1:0] CFG_YR_HI = 2'd1;

	// Reset values
	localparam logic [YEAR_W-1:0] YR_LO_RST = 14'd2020;
	localparam logic [YEAR_W-1:0] YR_HI_RST = 14'd2040;
	localparam logic [YEAR_W-1:0] YEAR_RST  = 14'd2020;

	// Reciprocal of 25 scaled by 2^17, exact for all 14-bit values
	localparam logic [12:0] RECIP25 = 13'd5243;

	// True when y is a multiple of 25
	function automatic logic mult25(input logic [YEAR_W-1:0] y);
		logic [26:0] prod;
		logic [9:0]  quo;
		logic [YEAR_W-1:0] back;
		prod = 27'(y) * 27'(RECIP25);
		quo  = prod[26:17];
		back = 14'(quo) * 14'd25;
		return y == back;
	endfunction

	// Gregorian leap-year test
	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		logic by4;
		logic by25;
		by4  = (y[1:0] == 2'b00);
		by25 = mult25(y);
		return (by4 && !by25) || (y[3:0] == 4'b0000 && by25);
	endfunction

	// Length of month m; months outside 1..12 give 31
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Clamp to the lower bound, then the upper bound
	function automatic logic [YEAR_W-1:0] fit_year(input logic [YEAR_W-1:0] y,
			input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
		logic [YEAR_W-1:0] r;
		r = y;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

endpackage

/* sv/button_date_editor_core.sv */
// Top level of the button date editor: input register, edit logic, result register.
//
// Channel | Direction | Handshake           | Beat contents
// in      | input     | in_valid/in_ready   | operation, start date, list and task numbers
// out     | output    | out_valid/out_ready | event_res, date, focus, tags
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (lowest and highest year)
//
// One beat in, one beat out; an accepted item passes through the input register and then the result register.
// A new item is taken every cycle as long as the result register drains.
// The edit state updates when an item leaves the input register for the result register.
// Reset restores year range 2020..2040, closed editor, date 1/1/2020, zero tags.
// cfg_ready is always high; writes to unused indexes are dropped.
module button_date_editor_core
	import bde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        operation,
	input  logic [3:0]        start_month,
	input  logic [4:0]        start_day,
	input  logic [YEAR_W-1:0] start_year,
	input  logic [7:0]        list_number,
	input  logic [7:0]        task_number,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        event_res,
	output logic [3:0]        month,
	output logic [4:0]        day,
	output logic [YEAR_W-1:0] year,
	output logic [1:0]        focus,
	output logic [7:0]        list_tag,
	output logic [7:0]        task_tag,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [YEAR_W-1:0] cfg_data
);

	// Configuration and edit state
	logic [YEAR_W-1:0] yr_lo_q, yr_hi_q;
	logic              open_q;
	logic [1:0]        focus_q;
	logic [3:0]        month_q;
	logic [4:0]        day_q;
	logic [YEAR_W-1:0] year_q;
	logic [7:0]        list_q, task_q;

	// Input register
	logic              valid_s1;
	logic [2:0]        op_s1;
	logic [3:0]        smonth_s1;
	logic [4:0]        sday_s1;
	logic [YEAR_W-1:0] syear_s1;
	logic [7:0]        list_s1, task_s1;

	// Result register
	logic              valid_s2;
	logic [1:0]        res_s2;
	logic [3:0]        month_s2;
	logic [4:0]        day_s2;
	logic [YEAR_W-1:0] year_s2;
	logic [1:0]        focus_s2;
	logic [7:0]        list_s2, task_s2;

	// Next-state values
	logic              adv;
	logic              nx_open, nx_fit_day, nx_fit_year;
	logic [1:0]        nx_res, nx_focus;
	logic [3:0]        nx_month;
	logic [4:0]        nx_day, dim, dim_cur, fday;
	logic [YEAR_W-1:0] nx_year, fyear;
	logic [7:0]        nx_list, nx_task;
	logic signed [5:0]  mstep;
	logic signed [6:0]  dstep;
	logic signed [15:0] ystep;

	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	// Length of the month for the date being edited
	assign dim = month_days(nx_month, leap_year(nx_year));

	// Length of the month for the stored date
	assign dim_cur = month_days(month_q, leap_year(year_q));

	// Decode the event against the current state
	always_comb begin
		nx_open     = open_q;
		nx_focus    = focus_q;
		nx_month    = month_q;
		nx_day      = day_q;
		nx_year     = year_q;
		nx_list     = list_q;
		nx_task     = task_q;
		nx_res      = RES_UPDATED;
		nx_fit_day  = 1'b0;
		nx_fit_year = 1'b0;
		mstep       = '0;
		dstep       = '0;
		ystep       = '0;
		if (op_s1 == OP_START) begin
			if (smonth_s1 == 4'd0) nx_month = 4'd1;
			else if (smonth_s1 > 4'd12) nx_month = 4'd12;
			else nx_month = smonth_s1;
			nx_day     = sday_s1;
			nx_year    = fit_year(syear_s1, yr_lo_q, yr_hi_q);
			nx_list    = list_s1;
			nx_task    = task_s1;
			nx_focus   = SEL_MONTH;
			nx_open    = 1'b1;
			nx_fit_day = 1'b1;
		end else if (!open_q) begin
			nx_res = RES_IGNORED;
		end else begin
			case (op_s1)
				OP_UP, OP_DOWN: begin
					if (focus_q == SEL_MONTH) begin
						mstep = (op_s1 == OP_UP) ? $signed({2'b00, month_q}) + 6'sd1
							: $signed({2'b00, month_q}) - 6'sd1;
						if (mstep > 6'sd12) mstep = 6'sd1;
						if (mstep < 6'sd1) mstep = 6'sd12;
						nx_month   = mstep[3:0];
						nx_fit_day = 1'b1;
					end else if (focus_q == SEL_DAY) begin
						dstep = (op_s1 == OP_UP) ? $signed({2'b00, day_q}) + 7'sd1
							: $signed({2'b00, day_q}) - 7'sd1;
						if (dstep > $signed({2'b00, dim_cur})) dstep = 7'sd1;
						if (dstep < 7'sd1) dstep = $signed({2'b00, dim_cur});
						nx_day = dstep[4:0];
					end else begin
						ystep = (op_s1 == OP_UP) ? $signed({2'b00, year_q}) + 16'sd1
							: $signed({2'b00, year_q}) - 16'sd1;
						if (ystep > $signed({2'b00, yr_hi_q}))
							ystep = $signed({2'b00, yr_lo_q});
						if (ystep < $signed({2'b00, yr_lo_q}))
							ystep = $signed({2'b00, yr_hi_q});
						nx_year    = ystep[YEAR_W-1:0];
						nx_fit_day = 1'b1;
					end
				end
				OP_SELECT: begin
					nx_fit_day = 1'b1;
					if (focus_q < SEL_YEAR) begin
						nx_focus = focus_q + 2'd1;
					end else begin
						nx_fit_year = 1'b1;
						nx_open     = 1'b0;
						nx_res      = RES_COMMITTED;
					end
				end
				OP_BACK: begin
					if (focus_q != SEL_MONTH) begin
						nx_focus = focus_q - 2'd1;
					end else begin
						nx_open = 1'b0;
						nx_res  = RES_CANCELLED;
					end
				end
				default: begin
					nx_res = RES_UPDATED;
				end
			endcase
		end
	end

	// Clamp the day to the month, then the year to the range on commit
	always_comb begin
		fday = nx_day;
		if (nx_fit_day) begin
			if (fday > dim) fday = dim;
			if (fday == 5'd0) fday = 5'd1;
		end
		fyear = nx_fit_year ? fit_year(nx_year, yr_lo_q, yr_hi_q) : nx_year;
	end

	// Control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			yr_lo_q  <= YR_LO_RST;
			yr_hi_q  <= YR_HI_RST;
			open_q   <= 1'b0;
			focus_q  <= SEL_MONTH;
			month_q  <= 4'd1;
			day_q    <= 5'd1;
			year_q   <= YEAR_RST;
			list_q   <= 8'd0;
			task_q   <= 8'd0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
			if (cfg_valid && cfg_index == CFG_YR_LO) yr_lo_q <= cfg_data;
			if (cfg_valid && cfg_index == CFG_YR_HI) yr_hi_q <= cfg_data;
			if (adv) begin
				open_q  <= nx_open;
				focus_q <= nx_focus;
				month_q <= nx_month;
				day_q   <= fday;
				year_q  <= fyear;
				list_q  <= nx_list;
				task_q  <= nx_task;
			end
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= operation;
			smonth_s1 <= start_month;
			sday_s1   <= start_day;
			syear_s1  <= start_year;
			list_s1   <= list_number;
			task_s1   <= task_number;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2   <= nx_res;
			month_s2 <= nx_month;
			day_s2   <= fday;
			year_s2  <= fyear;
			focus_s2 <= nx_focus;
			list_s2  <= nx_list;
			task_s2  <= nx_task;
		end
	end

	assign out_valid = valid_s2;
	assign event_res = res_s2;
	assign month     = month_s2;
	assign day       = day_s2;
	assign year      = year_s2;
	assign focus     = focus_s2;
	assign list_tag  = list_s2;
	assign task_tag  = task_s2;

endmodule
